// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the top-level RTL file of the LRU lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, silent while arst_n is low.
`define FLRU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, silent while arst_n is low.
`define FLRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/flru_pkg.sv -----
// Types and constants of the fully associative LRU lookup block.
package flru_pkg;

	localparam int ITEM_W = 12;   // item number width
	localparam int SLOT_W = 4;    // slot field width on the result
	localparam int IDX_W  = 6;    // slot number / rank width on the chain (up to 64 slots)
	localparam int DIV_SH = 24;   // shift of the reciprocal used for the item reduction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MOD,
		ST_FIND,
		ST_UPD
	} flru_state_t;

	// Search result, accumulated from cell to cell along the chain.
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_slot;
		logic [IDX_W-1:0]  hit_rank;
		logic [IDX_W-1:0]  vic_slot;
		logic              vic_full;
		logic [ITEM_W-1:0] vic_item;
	} flru_find_t;

	// Update broadcast to every cell.
	typedef struct packed {
		logic              en;
		logic              hit;
		logic [IDX_W-1:0]  slot;
		logic [IDX_W-1:0]  old_rank;
		logic [ITEM_W-1:0] key;
	} flru_upd_t;

endpackage

// ----- hw/rtl/flru_cell.sv -----
// One slot of the lookup: item tag, occupancy and recency rank.
module flru_cell #(
	parameter int BLOCKS = 16,
	parameter int IDX    = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [flru_pkg::ITEM_W-1:0]   key,
	input  flru_pkg::flru_find_t          find_in,
	output flru_pkg::flru_find_t          find_out,
	input  flru_pkg::flru_upd_t           upd
);

	localparam int RANK_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam logic [RANK_W-1:0] RANK_RST = (IDX == 0) ? '0 : RANK_W'(BLOCKS - IDX);
	localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(BLOCKS - 1);
	localparam logic [flru_pkg::IDX_W-1:0] MY_IDX = flru_pkg::IDX_W'(IDX);

	logic [flru_pkg::ITEM_W-1:0] item_q;
	logic                        full_q;
	logic [RANK_W-1:0]           rank_q;
	logic                        match;
	logic                        victim;
	logic                        winner;

	assign match  = full_q && (item_q == key);
	assign victim = (rank_q == '0);
	assign winner = (upd.slot == MY_IDX);

	// Merge this slot into the search result; at most one slot matches, one has rank 0.
	always_comb begin
		find_out = find_in;
		if (match) begin
			find_out.hit      = 1'b1;
			find_out.hit_slot = find_in.hit_slot | MY_IDX;
			find_out.hit_rank = find_in.hit_rank | flru_pkg::IDX_W'(rank_q);
		end
		if (victim) begin
			find_out.vic_slot = find_in.vic_slot | MY_IDX;
			find_out.vic_full = find_in.vic_full | full_q;
			find_out.vic_item = find_in.vic_item | item_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			rank_q <= RANK_RST;
		end else if (upd.en) begin
			if (winner) begin
				rank_q <= RANK_TOP;
				if (!upd.hit) begin
					full_q <= 1'b1;
				end
			end else if (rank_q > upd.old_rank[RANK_W-1:0]) begin
				rank_q <= rank_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && winner && !upd.hit) begin
			item_q <= upd.key;
		end
	end

endmodule

// ----- hw/rtl/fully_associative_lru_lookup.sv -----
// Top level of the fully associative LRU lookup: control, item reduction and the slot chain.
//
//  channel | dir | tdata fields (lowest bit first)                            | tuser / tlast
//  s_      | in  | item_index[11:0], zero pad to 16 bits                      | none
//  m_      | out | hit, slot[3:0], evicted_valid, evicted_index[11:0], pad 24 | none
//
// A request passes through the reduction of the item number modulo ITEMS
// (reciprocal multiply, then the remainder), the search along the chain of slot
// cells, and the update of the cells together with the load of the result register.
// Requests are handled one at a time: a new one is taken only once the block is
// back in its idle state.
// Reset is asynchronous: every slot empty, recency order slot 0 first, then
// BLOCKS-1 down to 1; no clearing pass. A stalled result holds the block in its
// update step; a new request is still taken while the last result waits.
`include "assert_macros.svh"

module fully_associative_lru_lookup #(
	parameter int BLOCKS = 16,
	parameter int ITEMS  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] item_index, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] hit, [4:1] slot, [5] evicted_valid,
	                               // [17:6] evicted_index, [23:18] zero
);

	localparam int IW = flru_pkg::ITEM_W;
	localparam int RW = 24;
	// Reciprocal of ITEMS, exact floor quotient for any 12-bit item number.
	localparam longint unsigned RECIP_L = ((64'd1 << flru_pkg::DIV_SH) + ITEMS - 1) / ITEMS;
	localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
	localparam logic [IW-1:0]   ITEMS_LO = IW'(ITEMS);

	flru_pkg::flru_state_t state_q, state_nxt;

	logic [IW-1:0]         item_q;
	logic [IW-1:0]         quot_q;
	logic [IW-1:0]         key_q;
	logic [IW+RW-1:0]      quot_prod;
	logic [IW-1:0]         rem_prod;
	flru_pkg::flru_find_t  find_q;
	flru_pkg::flru_find_t  chain [BLOCKS+1];
	flru_pkg::flru_upd_t   upd;
	logic                  upd_go;
	logic                  upd_stall;
	logic                  out_free;
	logic                  m_tvalid_q;
	logic [23:0]           m_tdata_q;
	logic                  ev_valid;

	assign out_free  = !m_tvalid_q || m_tready;
	assign upd_stall = (state_q == flru_pkg::ST_UPD) && !out_free;

	// ---- next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			flru_pkg::ST_IDLE: if (s_tvalid) state_nxt = flru_pkg::ST_DIV;
			flru_pkg::ST_DIV:  state_nxt = flru_pkg::ST_MOD;
			flru_pkg::ST_MOD:  state_nxt = flru_pkg::ST_FIND;
			flru_pkg::ST_FIND: state_nxt = flru_pkg::ST_UPD;
			flru_pkg::ST_UPD:  if (out_free) state_nxt = flru_pkg::ST_IDLE;
			default:           state_nxt = flru_pkg::ST_IDLE;
		endcase
	end

	// ---- state outputs
	always_comb begin
		s_tready = 1'b0;
		upd_go   = 1'b0;
		case (state_q)
			flru_pkg::ST_IDLE: s_tready = 1'b1;
			flru_pkg::ST_UPD:  upd_go   = out_free;
			default: begin
				s_tready = 1'b0;
				upd_go   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flru_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---- item reduction: quotient by reciprocal, then remainder in 12 bits
	assign quot_prod = item_q * RECIP;
	assign rem_prod  = IW'(quot_q * ITEMS_LO);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= s_tdata[IW-1:0];
		end
		if (state_q == flru_pkg::ST_DIV) begin
			quot_q <= quot_prod[flru_pkg::DIV_SH +: IW];
		end
		if (state_q == flru_pkg::ST_MOD) begin
			key_q <= item_q - rem_prod;
		end
	end

	// ---- chain of slot cells
	assign chain[0] = '0;

	for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
		flru_cell #(
			.BLOCKS (BLOCKS),
			.IDX    (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.find_in  (chain[i]),
			.find_out (chain[i+1]),
			.upd      (upd)
		);
	end

	// Hold the search result for the update step.
	always_ff @(posedge clk) begin
		if (state_q == flru_pkg::ST_FIND) begin
			find_q <= chain[BLOCKS];
		end
	end

	// Broadcast the winner; on a miss the victim has rank 0.
	always_comb begin
		upd.en       = upd_go;
		upd.hit      = find_q.hit;
		upd.slot     = find_q.hit ? find_q.hit_slot : find_q.vic_slot;
		upd.old_rank = find_q.hit ? find_q.hit_rank : '0;
		upd.key      = key_q;
	end

	assign ev_valid = !find_q.hit && find_q.vic_full;

	// ---- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			m_tdata_q <= {6'd0,
			              ev_valid ? find_q.vic_item : {IW{1'b0}},
			              ev_valid,
			              upd.slot[flru_pkg::SLOT_W-1:0],
			              find_q.hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---- checks
	`FLRU_ASSERT_NEXT(a_accept_starts_div, s_tvalid && s_tready, state_q == flru_pkg::ST_DIV)
	`FLRU_ASSERT_NEXT(a_stall_holds_upd, upd_stall, state_q == flru_pkg::ST_UPD)
	`FLRU_ASSERT_NOW(a_hit_no_evict, m_tvalid && m_tdata[0], !m_tdata[5] && m_tdata[17:6] == 12'd0)
	`FLRU_ASSERT_NOW(a_no_evict_zero, m_tvalid && !m_tdata[5], m_tdata[17:6] == 12'd0)

endmodule

// ----- tb/fully_associative_lru_lookup_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for the LRU lookup: tracks slot contents and recency, checks each result transaction.
module fully_associative_lru_lookup_check #(
	parameter int BLOCKS = 16,
	parameter int ITEMS  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          request_count,
	output int          hit_count,
	output int          evict_count
);

	// Laid out as on m_tdata: hit in the lowest bit, evicted item number on top.
	typedef struct packed {
		logic [flru_pkg::ITEM_W-1:0] ev_index;
		logic                        ev_valid;
		logic [flru_pkg::SLOT_W-1:0] slot;
		logic                        hit;
	} lookup_res_t;

	logic [flru_pkg::ITEM_W-1:0] held_item [BLOCKS];
	logic                        held_full [BLOCKS];
	logic [flru_pkg::IDX_W-1:0]  recency   [BLOCKS];
	lookup_res_t                 due_results [$];
	lookup_res_t                 want_res;
	lookup_res_t                 got_res;

	// Look the item up, replace the least recent slot on a miss, promote the slot.
	function automatic lookup_res_t lru_lookup(input logic [flru_pkg::ITEM_W-1:0] req);
		logic [flru_pkg::ITEM_W-1:0] key;
		int                          found;
		logic                        found_hit;
		int                          old_rank;
		lookup_res_t                 res;
		key       = flru_pkg::ITEM_W'(req % ITEMS);
		found     = 0;
		found_hit = 1'b0;
		res       = '0;
		for (int s = 0; s < BLOCKS; s++) begin
			if (!found_hit && held_full[s] && held_item[s] == key) begin
				found     = s;
				found_hit = 1'b1;
			end
		end
		if (!found_hit) begin
			// ranks are unique, so exactly one slot has rank zero
			for (int s = 0; s < BLOCKS; s++) begin
				if (recency[s] == '0)
					found = s;
			end
			if (held_full[found]) begin
				res.ev_valid = 1'b1;
				res.ev_index = held_item[found];
			end
			held_item[found] = key;
			held_full[found] = 1'b1;
		end
		old_rank = recency[found];
		for (int k = 0; k < BLOCKS; k++) begin
			if (recency[k] > old_rank)
				recency[k] = recency[k] - 1'b1;
		end
		recency[found] = flru_pkg::IDX_W'(BLOCKS - 1);
		res.hit  = found_hit;
		res.slot = flru_pkg::SLOT_W'(found);
		return res;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < BLOCKS; s++) begin
				held_item[s] = '0;
				held_full[s] = 1'b0;
				recency[s]   = (s == 0) ? '0 : flru_pkg::IDX_W'(BLOCKS - s);
			end
			due_results.delete();
			errors        = 0;
			pending       = 0;
			results_seen  = 0;
			request_count = 0;
			hit_count     = 0;
			evict_count   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got_res = m_tdata[17:0];
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: result with nothing outstanding, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want_res = due_results.pop_front();
					compare_field("hit", want_res.hit, got_res.hit);
					compare_field("slot", want_res.slot, got_res.slot);
					compare_field("evicted_valid", want_res.ev_valid, got_res.ev_valid);
					compare_field("evicted_index", want_res.ev_index, got_res.ev_index);
					compare_field("padding", 0, m_tdata[23:18]);
				end
			end
			if (s_tvalid && s_tready) begin
				want_res = lru_lookup(s_tdata[flru_pkg::ITEM_W-1:0]);
				due_results.push_back(want_res);
				request_count++;
				if (want_res.hit)
					hit_count++;
				if (want_res.ev_valid)
					evict_count++;
			end
			pending = due_results.size();
		end
	end

endmodule

// ----- tb/fully_associative_lru_lookup_test.sv -----
`timescale 1ns / 100ps
// Top of the LRU lookup testbench: clock, reset, request and result traffic, verdict.
module fully_associative_lru_lookup_test;

	localparam int BLOCKS      = 16;
	localparam int ITEMS       = 4096;
	localparam int CYCLE_LIMIT = 200000;   // far above the slowest correct run
	localparam int RANDOM_REQS = 700;
	localparam int LONG_HOLD   = 80;       // receiver hold-off, long enough to back up the input

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [11:0] item_index, [15:12] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // [0] hit, [4:1] slot, [5] evicted_valid,
	                         // [17:6] evicted_index, [23:18] zero

	int errors;
	int pending;
	int results_seen;
	int request_count;
	int hit_count;
	int evict_count;
	int cycles = 0;

	fully_associative_lru_lookup #(
		.BLOCKS(BLOCKS),
		.ITEMS (ITEMS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	fully_associative_lru_lookup_check #(
		.BLOCKS(BLOCKS),
		.ITEMS (ITEMS)
	) watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.request_count(request_count),
		.hit_count    (hit_count),
		.evict_count  (evict_count)
	);

	// 10 ns clock: five high, five low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run if it drags on far beyond any correct run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: cycle limit reached with %0d results outstanding", $time, pending);
			$display("FAIL");
			$finish;
		end
	end

	// Idle length for either side: mostly none, sometimes a short one, rarely a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	// Offer one request after an idle gap and hold it until the block takes it.
	// Valid is left high after the transaction; the next call lowers it or reloads it.
	task automatic send_request(input logic [11:0] item, input int unsigned gap);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, item};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop offering and hold until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
	endtask

	// Receiver: random stalls in busy stretches, none in quiet ones, and one long hold-off
	// once traffic is flowing so that the block backs up and stalls its input.
	initial begin : sink
		int  stall_left;
		int  phase_count;
		bit  quiet;
		bit  long_hold_done;
		stall_left     = 0;
		phase_count    = 0;
		quiet          = 1'b0;
		long_hold_done = 1'b0;
		m_tready       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			phase_count++;
			if (phase_count % 150 == 0)
				quiet = !quiet;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!long_hold_done && results_seen >= 30) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD - 1;
				m_tready      <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sender: directed corner cases, then random requests drawn mostly from a small working set.
	initial begin : source
		logic [11:0] pool [32];
		int          pool_size;
		logic [11:0] item;
		int unsigned gap;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		pool_size = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extremes of the item number: misses into empty slots, then hits on both.
		send_request(12'h000, 0);
		send_request(12'hFFF, 1);
		send_request(12'h000, 0);
		send_request(12'hFFF, 0);
		// Fill the remaining slots with distinct bit patterns.
		for (int i = 1; i <= 14; i++)
			send_request(12'(i * 12'h111), 0);
		// Store full: ask again for two items that are already held.
		send_request(12'h555, 0);
		send_request(12'hAAA, 2);
		// Ask twice for the least recent item, then hit another held item.
		send_request(12'h000, 0);
		send_request(12'h000, 0);
		send_request(12'h111, 0);
		drain_results();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			// Refresh the working set now and then; its size sets the hit rate.
			if (n % 100 == 0) begin
				pool_size = $urandom_range(6, 28);
				for (int i = 0; i < pool_size; i++)
					pool[i] = 12'($urandom_range(0, 4095));
			end
			if (n == RANDOM_REQS / 2)
				drain_results();
			if ($urandom_range(0, 9) < 8)
				item = pool[$urandom_range(0, pool_size - 1)];
			else
				item = 12'($urandom_range(0, 4095));
			// Back-to-back stretch with no sender gaps.
			gap = (n >= 500 && n < 600) ? 0 : pick_gap();
			send_request(item, gap);
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("Ran %0d lookups: %0d hits, %0d misses, %0d of them evicting an item,",
			request_count, hit_count, request_count - hit_count, evict_count);
		$display("under random sender gaps and receiver stalls, with one long receiver hold.");
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/flru_pkg.sv
hw/rtl/flru_cell.sv
hw/rtl/fully_associative_lru_lookup.sv
tb/fully_associative_lru_lookup_check.sv
tb/fully_associative_lru_lookup_test.sv
